[src/tdm_pkg.sv]
// ----------------------------------------------------------------------------
// tdm_pkg: shared types and constants of the tank drive mixer
// Payload structs, queue entry type, configuration register indexes.
// ----------------------------------------------------------------------------
package tdm_pkg;

	localparam int THROTTLE_W = 12;
	localparam int STEER_W    = 12;
	localparam int SPEED_W    = 16;
	localparam int ID_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Steering neutral point
	localparam logic [STEER_W-1:0] NEUTRAL_STEER = STEER_W'(1500);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_MOTOR_ID  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MOTOR_ID = 3'd4;

	// Reset values
	localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 16'd1000;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd2000;
	localparam logic [SPEED_W-1:0] RAMP_STEP_RST = 16'd10;
	localparam logic [ID_W-1:0]    LEFT_ID_RST   = 8'd1;
	localparam logic [ID_W-1:0]    RIGHT_ID_RST  = 8'd2;

	typedef struct packed {
		logic [THROTTLE_W-1:0] throttle;
		logic [STEER_W-1:0]    steering;
		logic                  button;
	} in_item_t;

	typedef struct packed {
		logic               is_right;
		logic [ID_W-1:0]    motor_id;
		logic [SPEED_W-1:0] speed;
		logic               last;
	} out_item_t;

	// Clamped targets handed from front to back
	typedef struct packed {
		logic [SPEED_W-1:0] left_target;
		logic [SPEED_W-1:0] right_target;
	} target_pair_t;

	// Register values seen by the front (clamp bounds)
	typedef struct packed {
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] max_speed;
	} front_cfg_t;

	// Register values seen by the back (ramp and ids)
	typedef struct packed {
		logic [SPEED_W-1:0] ramp_step;
		logic [ID_W-1:0]    left_motor_id;
		logic [ID_W-1:0]    right_motor_id;
	} back_cfg_t;

endpackage

[src/tdm_front.sv]
// ----------------------------------------------------------------------------
// tdm_front: input acceptance and target mixing
// Tracks the button edge and inversion flag, mixes and clamps both targets.
// ----------------------------------------------------------------------------
module tdm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdm_pkg::front_cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tdm_pkg::in_item_t     in_data,
	output logic                  push,
	output tdm_pkg::target_pair_t push_data,
	input  logic                  q_full
);

	localparam int SUM_W = 15;
	localparam int CMP_W = tdm_pkg::SPEED_W + 2;

	logic                    button_prev_q;
	logic                    steer_inv_q;
	logic                    inv_next;
	logic signed [SUM_W-1:0] offset;
	logic signed [SUM_W-1:0] offset_adj;
	logic signed [SUM_W-1:0] throttle_s;
	logic signed [SUM_W-1:0] sum_left;
	logic signed [SUM_W-1:0] sum_right;

	function automatic logic [tdm_pkg::SPEED_W-1:0] clamp_target(
		input logic signed [SUM_W-1:0]        sum,
		input logic [tdm_pkg::SPEED_W-1:0]    lo,
		input logic [tdm_pkg::SPEED_W-1:0]    hi
	);
		logic signed [CMP_W-1:0] s;
		logic signed [CMP_W-1:0] lo_s;
		logic signed [CMP_W-1:0] hi_s;
		logic [tdm_pkg::SPEED_W-1:0] r;
		s    = CMP_W'(sum);
		lo_s = $signed({2'b00, lo});
		hi_s = $signed({2'b00, hi});
		priority if (s < lo_s) begin
			r = lo;
		end else if (s > hi_s) begin
			r = hi;
		end else begin
			r = s[tdm_pkg::SPEED_W-1:0];
		end
		return r;
	endfunction

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Toggle on a rising button edge; the new flag applies to this beat
	assign inv_next = steer_inv_q ^ (in_data.button & ~button_prev_q);

	always_comb begin
		throttle_s = $signed({{(SUM_W-tdm_pkg::THROTTLE_W){1'b0}}, in_data.throttle});
		offset     = $signed({{(SUM_W-tdm_pkg::STEER_W){1'b0}}, in_data.steering})
			- $signed({{(SUM_W-tdm_pkg::STEER_W){1'b0}}, tdm_pkg::NEUTRAL_STEER});
		offset_adj = inv_next ? -offset : offset;
		sum_left   = throttle_s + offset_adj;
		sum_right  = throttle_s - offset_adj;
		push_data.left_target  = clamp_target(sum_left, cfg.min_speed, cfg.max_speed);
		push_data.right_target = clamp_target(sum_right, cfg.min_speed, cfg.max_speed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_prev_q <= 1'b0;
			steer_inv_q   <= 1'b0;
		end else if (push) begin
			button_prev_q <= in_data.button;
			steer_inv_q   <= inv_next;
		end
	end

endmodule

[src/tdm_fifo.sv]
// ----------------------------------------------------------------------------
// tdm_fifo: short queue of target pairs
// Decouples the mixing front from the ramping back.
// ----------------------------------------------------------------------------
module tdm_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tdm_pkg::target_pair_t push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output tdm_pkg::target_pair_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tdm_pkg::target_pair_t mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/tdm_back.sv]
// ----------------------------------------------------------------------------
// tdm_back: slew limiting and result sequencing
// Ramps both kept levels toward their targets and emits left, then right.
// ----------------------------------------------------------------------------
module tdm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdm_pkg::back_cfg_t    cfg,
	input  logic                  q_valid,
	input  tdm_pkg::target_pair_t q_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tdm_pkg::out_item_t    out_data
);

	localparam int W = tdm_pkg::SPEED_W;

	logic                 out_valid_q;
	tdm_pkg::out_item_t   out_data_q;
	logic                 pend_q;
	logic [W-1:0]         pend_speed_q;
	logic [W-1:0]         left_level_q;
	logic [W-1:0]         right_level_q;
	logic [W-1:0]         left_next;
	logic [W-1:0]         right_next;
	logic                 load;

	function automatic logic [W-1:0] ramp_toward(
		input logic [W-1:0] level,
		input logic [W-1:0] target,
		input logic [W-1:0] step
	);
		logic [W:0]   up;
		logic [W:0]   dn;
		logic [W-1:0] r;
		up = {1'b0, level} + {1'b0, step};
		dn = {1'b0, level} - {1'b0, step};
		priority if (level < target) begin
			r = (up > {1'b0, target}) ? target : up[W-1:0];
		end else if (level > target) begin
			// borrow out of the top bit means the step went below zero
			r = (dn[W] || (dn[W-1:0] < target)) ? target : dn[W-1:0];
		end else begin
			r = level;
		end
		return r;
	endfunction

	assign left_next  = ramp_toward(left_level_q, q_data.left_target, cfg.ramp_step);
	assign right_next = ramp_toward(right_level_q, q_data.right_target, cfg.ramp_step);

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !pend_q && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			pend_q        <= 1'b0;
			left_level_q  <= '0;
			right_level_q <= '0;
		end else if (load) begin
			priority if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (q_valid) begin
				out_valid_q   <= 1'b1;
				pend_q        <= 1'b1;
				left_level_q  <= left_next;
				right_level_q <= right_next;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_data_q.is_right <= 1'b1;
				out_data_q.motor_id <= cfg.right_motor_id;
				out_data_q.speed    <= pend_speed_q;
				out_data_q.last     <= 1'b1;
			end else if (q_valid) begin
				out_data_q.is_right <= 1'b0;
				out_data_q.motor_id <= cfg.left_motor_id;
				out_data_q.speed    <= left_next;
				out_data_q.last     <= 1'b0;
				pend_speed_q        <= right_next;
			end
		end
	end

endmodule

[src/tank_drive_mixer_slew_limiter_top.sv]
// The left beat passes through the queue and the result register before it is
// offered; the right beat follows from the pending register once the left is taken.
// The single result port carries two beats per input, so the back pops a new target
// pair once both beats of the last are loaded; a QUEUE_DEPTH-entry queue absorbs output stalls.
// Reset: configuration registers return to their defaults, kept levels and inversion flag to 0.
// ----------------------------------------------------------------------------
// tank_drive_mixer_slew_limiter_top: differential drive mixer with slew limit
// Mixes throttle and steering into left/right targets, clamps them, and ramps
// each side's kept level toward its target by at most ramp_step per input.
// ----------------------------------------------------------------------------
module tank_drive_mixer_slew_limiter_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [tdm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tdm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tdm_pkg::in_item_t                   in_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output tdm_pkg::out_item_t                  out_data
);

	// Configuration registers
	logic [tdm_pkg::SPEED_W-1:0] min_speed_q;
	logic [tdm_pkg::SPEED_W-1:0] max_speed_q;
	logic [tdm_pkg::SPEED_W-1:0] ramp_step_q;
	logic [tdm_pkg::ID_W-1:0]    left_id_q;
	logic [tdm_pkg::ID_W-1:0]    right_id_q;

	tdm_pkg::front_cfg_t   front_cfg;
	tdm_pkg::back_cfg_t    back_cfg;

	// Front to queue, queue to back
	logic                  push;
	tdm_pkg::target_pair_t push_data;
	logic                  q_full;
	logic                  pop;
	logic                  q_valid;
	tdm_pkg::target_pair_t q_data;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= tdm_pkg::MIN_SPEED_RST;
			max_speed_q <= tdm_pkg::MAX_SPEED_RST;
			ramp_step_q <= tdm_pkg::RAMP_STEP_RST;
			left_id_q   <= tdm_pkg::LEFT_ID_RST;
			right_id_q  <= tdm_pkg::RIGHT_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdm_pkg::REG_MIN_SPEED:      min_speed_q <= cfg_data;
				tdm_pkg::REG_MAX_SPEED:      max_speed_q <= cfg_data;
				tdm_pkg::REG_RAMP_STEP:      ramp_step_q <= cfg_data;
				tdm_pkg::REG_LEFT_MOTOR_ID:  left_id_q   <= cfg_data[tdm_pkg::ID_W-1:0];
				tdm_pkg::REG_RIGHT_MOTOR_ID: right_id_q  <= cfg_data[tdm_pkg::ID_W-1:0];
				default: ;
			endcase
		end
	end

	assign front_cfg.min_speed     = min_speed_q;
	assign front_cfg.max_speed     = max_speed_q;
	assign back_cfg.ramp_step      = ramp_step_q;
	assign back_cfg.left_motor_id  = left_id_q;
	assign back_cfg.right_motor_id = right_id_q;

	// Front: take the input beat, track the button edge, mix and clamp.
	tdm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (front_cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Queue: hold clamped target pairs while the back is busy or stalled.
	tdm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	// Back: ramp both levels at pop, then advance left beat and right beat.
	tdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
